// File: hdl/flba_pkg.sv
package flba_pkg;

  // Pool geometry
  localparam int unsigned POOL_BLOCKS = 256;
  localparam int unsigned LINK_DEPTH  = 256;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned CNT_W       = 9;

  // Number of blocks that can ever be issued: the smaller of the pool and the link store.
  localparam logic [CNT_W-1:0] POOL_LIMIT =
    CNT_W'((POOL_BLOCKS > LINK_DEPTH) ? LINK_DEPTH : POOL_BLOCKS);
  localparam logic [CNT_W-1:0] IN_USE_MAX = '1;

  // Block size register and clamping limits
  localparam int unsigned        SIZE_W          = 13;
  localparam logic [SIZE_W-1:0]  MIN_BLOCK_BYTES = SIZE_W'(8);
  localparam logic [SIZE_W-1:0]  MAX_BLOCK_BYTES = SIZE_W'(4096);
  localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RST  = SIZE_W'(64);
  localparam int unsigned        ADDR_OUT_W      = 20;

  // Configuration port
  localparam int unsigned PADDR_W = 3;
  localparam logic [PADDR_W-3:0] REG_BLOCK_SIZE = '0;

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_EXHAUSTED   = 2'd1,
    STATUS_NONE_IN_USE = 2'd2
  } status_t;

  // One entry of the link store: the next block and the end-of-list mark
  typedef struct packed {
    logic             last;
    logic [IDX_W-1:0] next;
  } link_t;

  // A finished operation, handed from the control to the result stage
  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [CNT_W-1:0] in_use;
    logic [CNT_W-1:0] issued;
    status_t          status;
  } res_t;

  localparam int unsigned TDATA_OUT_W = 72;

endpackage

// File: hdl/free_list_block_allocator.sv
// Channel  | Signals                              | Item
// s_*      | s_tvalid s_tready s_tdata s_tuser    | operation request
// m_*      | m_tvalid m_tready m_tdata            | result of one operation
// APB      | psel penable pwrite paddr pwdata ... | block size register at 0x0
//
// A free, a fresh allocate and a failed allocate hand on their result when accepted;
// an allocate served from the free list reads the link of the head block and hands
// on its result in the pop state, as the new list head comes out of the link store.
// Reset is synchronous, clears the list head and the counts and sets the block size
// register back to 64; the link store is not cleared. Results wait in a two-entry
// output queue, so a new item is accepted while a result is held by a stalled sink.
module free_list_block_allocator
  import flba_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Request: tdata = block_index[7:0]; tuser = operation (0 allocate, 1 free)
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,
  input  logic                   s_tuser,
  // Result: tdata = result_index[7:0], result_address[27:8],
  //   effective_block_size[40:28], blocks_in_use[49:41], blocks_issued[58:50],
  //   blocks_idle[67:59], status[69:68], zero fill[71:70]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_OUT_W-1:0] m_tdata,
  // Configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  state_t            state, state_next;
  logic [IDX_W-1:0]  free_head, free_head_next;
  logic              list_empty, list_empty_next;
  logic [CNT_W-1:0]  issued_count, issued_count_next;
  logic [CNT_W-1:0]  in_use_count, in_use_count_next;
  logic [SIZE_W-1:0] size_cfg;
  logic [SIZE_W-1:0] eff_size;
  logic [CNT_W-1:0]  in_use_inc;

  logic              accept;
  logic              res_full;
  logic              push;
  res_t              push_item;
  logic              rd_en;
  logic              wr_en;
  link_t             wr_data;
  link_t             rd_data;
  logic              cfg_write;
  logic              cfg_hit;

  // Configuration port: writes complete in the access phase, never wait.
  assign pready    = 1'b1;
  assign cfg_hit   = (paddr[PADDR_W-1:2] == REG_BLOCK_SIZE);
  assign cfg_write = psel & penable & pwrite & pready & cfg_hit;
  assign prdata    = cfg_hit ? 32'(size_cfg) : '0;

  // The requested size is clamped to a usable block size.
  assign eff_size = (size_cfg < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES :
                    (size_cfg > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : size_cfg;

  assign s_tready   = (state == S_IDLE) && !res_full;
  assign accept     = s_tvalid & s_tready;
  assign in_use_inc = (in_use_count == IN_USE_MAX) ? in_use_count : in_use_count + 1'b1;

  // A free links the block in front of the current head; the end mark is set
  // when the list was empty, standing in for a null pointer.
  assign wr_data.last = list_empty;
  assign wr_data.next = free_head;

  always_comb begin
    state_next        = state;
    free_head_next    = free_head;
    list_empty_next   = list_empty;
    issued_count_next = issued_count;
    in_use_count_next = in_use_count;
    push              = 1'b0;
    push_item         = '0;
    rd_en             = 1'b0;
    wr_en             = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          if (s_tuser == OP_ALLOC) begin
            if (!list_empty) begin
              // Fetch the link of the head block; the result follows next cycle.
              rd_en             = 1'b1;
              in_use_count_next = in_use_inc;
              state_next        = S_POP;
            end else if (issued_count < POOL_LIMIT) begin
              push               = 1'b1;
              push_item.index    = issued_count[IDX_W-1:0];
              push_item.status   = STATUS_OK;
              issued_count_next  = issued_count + 1'b1;
              in_use_count_next  = in_use_inc;
            end else begin
              push             = 1'b1;
              push_item.status = STATUS_EXHAUSTED;
            end
          end else begin
            push            = 1'b1;
            push_item.index = s_tdata;
            if (in_use_count == '0) begin
              push_item.status = STATUS_NONE_IN_USE;
            end else begin
              push_item.status  = STATUS_OK;
              wr_en             = 1'b1;
              free_head_next    = s_tdata;
              list_empty_next   = 1'b0;
              in_use_count_next = in_use_count - 1'b1;
            end
          end
        end
      end
      S_POP: begin
        push             = 1'b1;
        push_item.index  = free_head;
        push_item.status = STATUS_OK;
        if (rd_data.last) begin
          list_empty_next = 1'b1;
        end else begin
          free_head_next = rd_data.next;
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    push_item.in_use = in_use_count_next;
    push_item.issued = issued_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      free_head    <= '0;
      list_empty   <= 1'b1;
      issued_count <= '0;
      in_use_count <= '0;
      size_cfg     <= BLOCK_SIZE_RST;
    end else begin
      state        <= state_next;
      free_head    <= free_head_next;
      list_empty   <= list_empty_next;
      issued_count <= issued_count_next;
      in_use_count <= in_use_count_next;
      if (cfg_write) begin
        size_cfg <= pwdata[SIZE_W-1:0];
      end
    end
  end

  flba_link_mem u_link_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s_tdata),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (free_head),
    .rd_data (rd_data)
  );

  flba_result u_result (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .eff_size  (eff_size),
    .full      (res_full),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// File: hdl/flba_link_mem.sv
module flba_link_mem
  import flba_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  link_t            wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output link_t            rd_data
);

  link_t mem [LINK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/flba_result.sv
module flba_result
  import flba_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  res_t                   push_item,
  input  logic [SIZE_W-1:0]      eff_size,
  output logic                   full,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_OUT_W-1:0] m_tdata
);

  // Result word, lowest field first:
  // index, address, size, in use, issued, idle, status, zero fill
  typedef struct packed {
    logic [1:0]            pad;
    status_t               status;
    logic [CNT_W-1:0]      idle;
    logic [CNT_W-1:0]      issued;
    logic [CNT_W-1:0]      in_use;
    logic [SIZE_W-1:0]     size;
    logic [ADDR_OUT_W-1:0] address;
    logic [IDX_W-1:0]      index;
  } word_t;

  word_t            head;
  word_t            skid;
  logic [1:0]       count;
  word_t            entry;
  logic [IDX_W+SIZE_W-1:0] product;
  logic             pop;

  assign product = (IDX_W+SIZE_W)'(push_item.index) * (IDX_W+SIZE_W)'(eff_size);

  always_comb begin
    entry         = '0;
    entry.index   = push_item.index;
    entry.address = product[ADDR_OUT_W-1:0];
    entry.size    = eff_size;
    entry.in_use  = push_item.in_use;
    entry.issued  = push_item.issued;
    entry.idle    = (push_item.issued > push_item.in_use) ?
                    push_item.issued - push_item.in_use : '0;
    entry.status  = push_item.status;
  end

  assign pop      = m_tvalid & m_tready;
  assign m_tvalid = (count != 2'd0);
  assign full     = (count == 2'd2);
  assign m_tdata  = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    case (count)
      2'd0: begin
        if (push) head <= entry;
      end
      2'd1: begin
        if (push && pop) head <= entry;
        else if (push)   skid <= entry;
      end
      2'd2: begin
        if (pop) begin
          head <= skid;
          if (push) skid <= entry;
        end
      end
      default: begin
        head <= head;
      end
    endcase
  end

endmodule

// File: verif/free_list_block_allocator_checker.sv
`timescale 1ns / 100ps

module free_list_block_allocator_checker
  import flba_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  // tdata = block_index[7:0]; tuser = operation
  input  logic [7:0]             s_tdata,
  input  logic                   s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  // tdata = result_index, result_address, effective_block_size, blocks_in_use,
  //   blocks_issued, blocks_idle, status, zero fill (lowest bits first)
  input  logic [TDATA_OUT_W-1:0] m_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [31:0]            pwdata,
  input  logic [31:0]            prdata,
  input  logic                   pready,
  output int                     error_count,
  output int                     outstanding
);

  // One result item as it lies on m_tdata, most significant field first.
  typedef struct packed {
    logic [1:0]            fill;
    logic [1:0]            status;
    logic [CNT_W-1:0]      idle;
    logic [CNT_W-1:0]      issued;
    logic [CNT_W-1:0]      in_use;
    logic [SIZE_W-1:0]     size;
    logic [ADDR_OUT_W-1:0] address;
    logic [IDX_W-1:0]      index;
  } op_report_t;

  logic [SIZE_W-1:0] size_reg;
  logic [IDX_W-1:0]  list_head;
  logic              list_empty;
  logic [IDX_W-1:0]  chain_next [LINK_DEPTH];
  logic              chain_end  [LINK_DEPTH];
  logic [CNT_W-1:0]  issued_blocks;
  logic [CNT_W-1:0]  blocks_held;
  op_report_t        pending_reports [$];

  initial begin
    error_count = 0;
    outstanding = 0;
  end

  // Applies one request to the pool state and returns the report it should produce.
  function automatic op_report_t serve_request(logic op, logic [IDX_W-1:0] idx);
    op_report_t        rep;
    logic [SIZE_W-1:0] eff;
    rep = '0;
    eff = size_reg;
    if (eff < MIN_BLOCK_BYTES) begin
      eff = MIN_BLOCK_BYTES;
    end else if (eff > MAX_BLOCK_BYTES) begin
      eff = MAX_BLOCK_BYTES;
    end
    rep.status = STATUS_OK;
    if (op == OP_ALLOC) begin
      if (!list_empty) begin
        rep.index = list_head;
        if (chain_end[rep.index]) begin
          list_empty = 1'b1;
        end else begin
          list_head = chain_next[rep.index];
        end
        if (blocks_held < IN_USE_MAX) blocks_held++;
      end else if (issued_blocks < POOL_LIMIT) begin
        rep.index = issued_blocks[IDX_W-1:0];
        issued_blocks++;
        if (blocks_held < IN_USE_MAX) blocks_held++;
      end else begin
        rep.status = STATUS_EXHAUSTED;
      end
    end else begin
      rep.index = idx;
      if (blocks_held == '0) begin
        rep.status = STATUS_NONE_IN_USE;
      end else begin
        chain_next[idx] = list_head;
        chain_end[idx]  = list_empty;
        list_head       = idx;
        list_empty      = 1'b0;
        blocks_held--;
      end
    end
    rep.address = ADDR_OUT_W'(32'(rep.index) * 32'(eff));
    rep.size    = eff;
    rep.in_use  = blocks_held;
    rep.issued  = issued_blocks;
    rep.idle    = (issued_blocks > blocks_held) ? issued_blocks - blocks_held : '0;
    return rep;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    op_report_t want;
    op_report_t got;
    if (rst) begin
      size_reg      = BLOCK_SIZE_RST;
      list_head     = '0;
      list_empty    = 1'b1;
      issued_blocks = '0;
      blocks_held   = '0;
      pending_reports.delete();
    end else begin
      if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_BLOCK_SIZE &&
          paddr[1:0] == 2'b00) begin
        if (pwrite) begin
          size_reg = pwdata[SIZE_W-1:0];
        end else begin
          check_field("prdata", 32'(size_reg), prdata);
        end
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_reports.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, got index %0d status %0d",
                   $time, got.index, got.status);
        end else begin
          want = pending_reports.pop_front();
          check_field("result_index", 32'(want.index), 32'(got.index));
          check_field("result_address", 32'(want.address), 32'(got.address));
          check_field("effective_block_size", 32'(want.size), 32'(got.size));
          check_field("blocks_in_use", 32'(want.in_use), 32'(got.in_use));
          check_field("blocks_issued", 32'(want.issued), 32'(got.issued));
          check_field("blocks_idle", 32'(want.idle), 32'(got.idle));
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("zero fill", 32'(want.fill), 32'(got.fill));
        end
      end
      if (s_tvalid && s_tready) pending_reports.push_back(serve_request(s_tuser, s_tdata));
    end
    outstanding = pending_reports.size();
  end

endmodule

// File: verif/free_list_block_allocator_tb.sv
`timescale 1ns / 100ps

module free_list_block_allocator_tb;
  import flba_pkg::*;

  // Byte address of the block size register, and of a slot that holds no register.
  localparam logic [PADDR_W-1:0] ADDR_BLOCK_SIZE = {REG_BLOCK_SIZE, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_SPARE      = PADDR_W'(4);
  // Length of the long sink stall, and the settling time given to the block once
  // every expected result has come back.
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // tdata = block_index[7:0]; tuser = operation (0 allocate, 1 free)
  logic [7:0]             s_tdata  = '0;
  logic                   s_tuser  = OP_ALLOC;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // tdata = result_index[7:0], result_address[27:8], effective_block_size[40:28],
  //   blocks_in_use[49:41], blocks_issued[58:50], blocks_idle[67:59],
  //   status[69:68], zero fill[71:70]
  logic [TDATA_OUT_W-1:0] m_tdata;
  logic                   psel     = 1'b0;
  logic                   penable  = 1'b0;
  logic                   pwrite   = 1'b0;
  logic [PADDR_W-1:0]     paddr    = '0;
  logic [31:0]            pwdata   = '0;
  logic [31:0]            prdata;
  logic                   pready;

  int error_count;
  int outstanding;

  // Percentages of cycles in which the source holds back an item and the sink
  // refuses one.
  int send_idle_pct = 33;
  int sink_idle_pct = 68;

  // The long sink stall is requested here and timed by the sink process itself.
  logic hold_request = 1'b0;
  int   hold_left    = 0;

  // Rough bookkeeping of which blocks the test currently holds, so that most frees
  // name a block that was really handed out. It follows the pool exactly only as
  // long as nothing is freed twice; it steers the stimulus and checks nothing.
  logic [IDX_W-1:0] spare_blocks [$];
  logic [IDX_W-1:0] held_blocks  [$];
  int               fresh_next = 0;

  free_list_block_allocator uut (.*);

  free_list_block_allocator_checker ledger (.*);

  always #1 clk = ~clk;

  // The sink changes its ready at the falling edge. During a long stall it keeps
  // ready low for the whole stall, whose length HOLD_CYCLES sets, otherwise it refuses at random.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Offers one item, starting and ending at a falling edge. Valid is left high
  // after the handshake so that back-to-back items keep it high without a glitch;
  // the next call, or quiesce, decides what it does next.
  task automatic send_item(input logic op, input logic [IDX_W-1:0] idx);
    int pos;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= idx;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (op == OP_ALLOC) begin
      if (spare_blocks.size() > 0) begin
        held_blocks.push_back(spare_blocks.pop_back());
      end else if (fresh_next < POOL_LIMIT) begin
        held_blocks.push_back(IDX_W'(fresh_next));
        fresh_next++;
      end
    end else if (held_blocks.size() > 0) begin
      spare_blocks.push_back(idx);
      pos = 0;
      foreach (held_blocks[i]) if (held_blocks[i] == idx) pos = i;
      held_blocks.delete(pos);
    end
  endtask

  // A mix of allocates and frees. Most frees return a block that is held; a stray
  // free names any index at all, which may be a double free or a block never issued.
  task automatic run_phase(input int count, input int alloc_pct, input int stray_pct);
    repeat (count) begin
      if ($urandom_range(99) < stray_pct) begin
        send_item(OP_FREE, IDX_W'($urandom));
      end else if ($urandom_range(99) < alloc_pct) begin
        send_item(OP_ALLOC, IDX_W'($urandom));
      end else if (held_blocks.size() == 0) begin
        send_item(OP_FREE, IDX_W'($urandom));
      end else begin
        send_item(OP_FREE, held_blocks[$urandom_range(held_blocks.size() - 1)]);
      end
    end
  endtask

  // One APB transfer: a setup phase, an access phase and then a quiet spell with psel low.
  task automatic apb_access(input logic write, input logic [PADDR_W-1:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Writes the block size and reads it straight back.
  task automatic set_block_size(input logic [31:0] value);
    apb_access(1'b1, ADDR_BLOCK_SIZE, value);
    apb_access(1'b0, ADDR_BLOCK_SIZE, '0);
  endtask

  // Stops offering items and waits until every expected result has been seen.
  task automatic quiesce;
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A write to an empty register slot must leave the block size alone, and the
    // reset value must read back.
    apb_access(1'b1, ADDR_SPARE, 32'h0000_0010);
    apb_access(1'b0, ADDR_BLOCK_SIZE, '0);

    // Directed part. A free with nothing in use is refused, whatever the index.
    send_item(OP_FREE, 8'd255);
    send_item(OP_FREE, 8'd0);
    // Fresh blocks come out in order 0, 1, 2.
    send_item(OP_ALLOC, IDX_W'($urandom));
    send_item(OP_ALLOC, IDX_W'($urandom));
    send_item(OP_ALLOC, IDX_W'($urandom));
    // Push onto an empty list, then onto a non-empty one; the pops come back in
    // reverse, and the second pop empties the list so that the next block is fresh.
    send_item(OP_FREE, 8'd1);
    send_item(OP_FREE, 8'd2);
    send_item(OP_ALLOC, IDX_W'($urandom));
    send_item(OP_ALLOC, IDX_W'($urandom));
    send_item(OP_ALLOC, IDX_W'($urandom));
    send_item(OP_FREE, 8'd0);
    send_item(OP_FREE, 8'd3);
    send_item(OP_ALLOC, IDX_W'($urandom));
    send_item(OP_ALLOC, IDX_W'($urandom));
    // Freeing a block that was never issued is accepted and the block reused.
    send_item(OP_FREE, 8'd255);
    send_item(OP_ALLOC, IDX_W'($urandom));
    send_item(OP_ALLOC, IDX_W'($urandom));
    send_item(OP_FREE, 8'd128);
    send_item(OP_FREE, 8'd127);
    send_item(OP_ALLOC, IDX_W'($urandom));
    send_item(OP_ALLOC, IDX_W'($urandom));
    quiesce;

    // Sizes below the minimum are clamped up to it.
    set_block_size(32'd1);
    set_block_size(32'd0);
    run_phase(200, 65, 0);
    quiesce;

    // The largest value the register holds is clamped down to the maximum.
    set_block_size(32'd8191);
    run_phase(200, 40, 0);
    quiesce;

    // Second idling pattern: a slow source and a mostly ready sink. The upper bits
    // of the write data lie outside the register and are dropped.
    send_idle_pct = 68;
    sink_idle_pct = 33;
    set_block_size(32'hFFFF_E005);
    set_block_size(32'd7);
    run_phase(250, 80, 0);
    quiesce;

    // Mostly allocates, so that the pool runs dry and keeps refusing.
    set_block_size(32'd8);
    set_block_size(32'd9);
    run_phase(150, 90, 0);
    quiesce;

    // No idling from here on. The sink stalls for a long stretch while the source
    // keeps offering, so the output queue fills and the input is held off.
    send_idle_pct = 0;
    sink_idle_pct = 0;
    set_block_size(32'd4096);
    @(posedge clk);
    hold_request = 1'b1;
    @(negedge clk);
    run_phase(200, 20, 0);
    quiesce;

    // Stray frees from now on, including double frees.
    set_block_size(32'd4097);
    run_phase(250, 55, 15);
    quiesce;

    // Freeing one block twice links it to itself, so every later allocate pops it
    // again; enough of them drive the in-use count into saturation.
    set_block_size($urandom_range(8191));
    send_item(OP_FREE, 8'd42);
    send_item(OP_FREE, 8'd42);
    run_phase(460, 100, 0);
    run_phase(30, 30, 20);
    quiesce;

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
